// ----- hdl/bfa_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

    localparam int WORD_BITS = 32;
    localparam int BIT_W     = 5;
    localparam int FRAME_W   = 11;
    localparam int IDX_W     = 10;
    localparam int WI_W      = FRAME_W - BIT_W;
    localparam int FRAME_MAX = (1 << FRAME_W) - 1;
    localparam int FC_RESET  = 1024;
    localparam int DATA_W    = 32;
    localparam int ADDR_W    = 3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic REG_FRAME_COUNT = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MARK,
        ST_FREE_RD,
        ST_FREE_WR,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic               hit;
        logic [BIT_W-1:0]   bit_pos;
        logic [FRAME_W-1:0] run_out;
    } find_t;

    typedef struct packed {
        logic               success;
        logic [IDX_W-1:0]   first_frame;
        logic [FRAME_W-1:0] used_count;
    } result_t;

endpackage

// ----- hdl/bitmap_frame_allocator.sv -----
// Bitmap frame allocator top level: register port, result register, bitmap memory.
//
// Input channel (in_valid/in_ready) carries one transaction per request:
// cmd selects allocate of a run_length-frame contiguous run or free of
// frame_index. Output channel (out_valid/out_ready) returns one transaction
// per request: success, first_frame of the run, and used_count after it.
// An allocate reads the bitmap one 32-frame word per cycle until the first
// fit, then rewrites the words of the run one per cycle; at most
// ceil(frame_count/32) words are scanned. The bitmap memory port moves one
// word per cycle. One request is in work at a time, and the next is taken
// while the previous result waits. frame_count sits at byte address 0 of
// the register port. After reset, and after every frame_count write, the
// map is cleared one word per cycle, all ceil(NUM_FRAMES/32) words, with
// in_ready low. A stalled receiver holds the result register; the request
// after it finishes, then waits until the register is free.
module bitmap_frame_allocator #(
    parameter int NUM_FRAMES = 1024
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bfa_pkg::ADDR_W-1:0]   paddr,
    input  logic [bfa_pkg::DATA_W-1:0]   pwdata,
    output logic [bfa_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         cmd,
    input  logic [bfa_pkg::FRAME_W-1:0]  run_length,
    input  logic [bfa_pkg::IDX_W-1:0]    frame_index,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         success,
    output logic [bfa_pkg::IDX_W-1:0]    first_frame,
    output logic [bfa_pkg::FRAME_W-1:0]  used_count
);
    import bfa_pkg::*;

    localparam int WORDS  = (NUM_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int FC_MAX = (NUM_FRAMES > FRAME_MAX) ? FRAME_MAX : NUM_FRAMES;
    localparam int FC_RST = (NUM_FRAMES < FC_RESET) ? NUM_FRAMES : FC_RESET;

    logic [FRAME_W-1:0]   fc_reg, fc_next;
    logic                 cfg_wr;
    logic                 reg_sel;
    logic [FRAME_W-1:0]   fc_wdata;

    logic                 res_valid;
    logic                 res_take;
    result_t              res;
    result_t              out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    logic                 mem_wr_en;
    logic [AW-1:0]        mem_wr_addr;
    logic [WORD_BITS-1:0] mem_wr_data;
    logic [AW-1:0]        mem_rd_addr;
    logic [WORD_BITS-1:0] mem_rd_data;

    assign pready   = 1'b1;
    assign reg_sel  = (paddr[2] == REG_FRAME_COUNT);
    assign cfg_wr   = psel && penable && pwrite && pready && reg_sel;
    assign fc_wdata = (32'(pwdata[FRAME_W-1:0]) > 32'(NUM_FRAMES))
                      ? FRAME_W'(FC_MAX) : pwdata[FRAME_W-1:0];
    assign fc_next  = cfg_wr ? fc_wdata : fc_reg;
    assign prdata   = reg_sel ? DATA_W'(fc_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fc_reg <= FRAME_W'(FC_RST);
        end
        else
        begin
            fc_reg <= fc_next;
        end
    end

    bfa_map_ram #(
        .DEPTH (WORDS),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    bfa_ctrl #(
        .WORDS (WORDS),
        .AW    (AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .cmd         (cmd),
        .run_length  (run_length),
        .frame_index (frame_index),
        .frame_count (fc_reg),
        .cfg_clear   (cfg_wr),
        .res_valid   (res_valid),
        .res_take    (res_take),
        .res         (res),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    assign res_take = !out_valid_reg || out_ready;

    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_next       = res;
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_valid   = out_valid_reg;
    assign success     = out_reg.success;
    assign first_frame = out_reg.first_frame;
    assign used_count  = out_reg.used_count;

endmodule

// ----- hdl/bfa_map_ram.sv -----
// Used/free bitmap memory: one write port, one registered read port.
module bfa_map_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [AW-1:0]                 wr_addr,
    input  logic [bfa_pkg::WORD_BITS-1:0] wr_data,
    input  logic [AW-1:0]                 rd_addr,
    output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);
    import bfa_pkg::*;

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- hdl/bfa_run_finder.sv -----
// Finds the lowest bit of one bitmap word where a free run reaches the wanted length.
module bfa_run_finder (
    input  logic [bfa_pkg::WORD_BITS-1:0] word,
    input  logic [bfa_pkg::FRAME_W-1:0]   run_in,
    input  logic [bfa_pkg::FRAME_W-1:0]   run_length,
    output bfa_pkg::find_t                res
);
    import bfa_pkg::*;

    logic [BIT_W:0]       cur [WORD_BITS];
    logic [BIT_W:0]       nxt [WORD_BITS];
    logic [FRAME_W:0]     run_b [WORD_BITS];
    logic [WORD_BITS-1:0] hit_vec;

    // prefix scan: highest used bit at or below each position
    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            cur[i] = word[i] ? {1'b1, BIT_W'(i)} : '0;
            nxt[i] = '0;
        end
        for (int lvl = 0; lvl < BIT_W; lvl++)
        begin
            for (int i = 0; i < WORD_BITS; i++)
            begin
                if ((i >= (1 << lvl)) && !cur[i][BIT_W])
                begin
                    nxt[i] = cur[i - (1 << lvl)];
                end
                else
                begin
                    nxt[i] = cur[i];
                end
            end
            for (int i = 0; i < WORD_BITS; i++)
            begin
                cur[i] = nxt[i];
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < WORD_BITS; i++)
        begin
            if (cur[i][BIT_W])
            begin
                run_b[i] = (FRAME_W + 1)'(BIT_W'(i) - cur[i][BIT_W-1:0]);
            end
            else
            begin
                run_b[i] = {1'b0, run_in} + (FRAME_W + 1)'(i + 1);
            end
            hit_vec[i] = (run_b[i] >= {1'b0, run_length});
        end
    end

    always_comb
    begin
        res.hit     = |hit_vec;
        res.bit_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                res.bit_pos = BIT_W'(i);
            end
        end
        if (cur[WORD_BITS-1][BIT_W])
        begin
            res.run_out = FRAME_W'(BIT_W'(WORD_BITS - 1) - cur[WORD_BITS-1][BIT_W-1:0]);
        end
        else
        begin
            res.run_out = run_in + FRAME_W'(WORD_BITS);
        end
    end

endmodule

// ----- hdl/bfa_ctrl.sv -----
// Sequencer: clear pass, word-serial first-fit scan, run marking and frame free.
module bfa_ctrl #(
    parameter int WORDS = 32,
    parameter int AW    = 5
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          cmd,
    input  logic [bfa_pkg::FRAME_W-1:0]   run_length,
    input  logic [bfa_pkg::IDX_W-1:0]     frame_index,
    input  logic [bfa_pkg::FRAME_W-1:0]   frame_count,
    input  logic                          cfg_clear,
    output logic                          res_valid,
    input  logic                          res_take,
    output bfa_pkg::result_t              res,
    output logic                          mem_wr_en,
    output logic [AW-1:0]                 mem_wr_addr,
    output logic [bfa_pkg::WORD_BITS-1:0] mem_wr_data,
    output logic [AW-1:0]                 mem_rd_addr,
    input  logic [bfa_pkg::WORD_BITS-1:0] mem_rd_data
);
    import bfa_pkg::*;

    state_t               state_reg, state_next;
    logic [FRAME_W-1:0]   len_reg, len_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [FRAME_W-1:0]   used_reg, used_next;
    logic [FRAME_W-1:0]   run_reg, run_next;
    logic [FRAME_W-1:0]   start_reg, start_next;
    logic [FRAME_W-1:0]   end_reg, end_next;
    logic                 ok_reg, ok_next;
    logic [WI_W-1:0]      ptr_reg, ptr_next;
    logic [WI_W-1:0]      wd_reg, wd_next;
    logic                 live_reg, live_next;
    logic [AW-1:0]        clr_reg, clr_next;

    logic                 accept;
    logic                 alloc_ok;
    logic                 free_ok;
    logic                 clr_last;
    logic [FRAME_W-1:0]   fc_m1;
    logic [WI_W-1:0]      last_word;
    logic [BIT_W-1:0]     tail;
    logic [WORD_BITS-1:0] lim_mask;
    logic [WORD_BITS-1:0] scan_word;
    find_t                fnd;
    logic [FRAME_W-1:0]   hit_end;
    logic [FRAME_W-1:0]   hit_start;
    logic [BIT_W-1:0]     mk_lo;
    logic [BIT_W-1:0]     mk_hi;
    logic [WORD_BITS-1:0] mark_mask;
    logic                 fbit;
    logic [WORD_BITS-1:0] fmask;

    assign accept    = in_valid && in_ready;
    assign alloc_ok  = (run_length != '0) && (run_length <= frame_count);
    assign free_ok   = ({1'b0, frame_index} < frame_count);
    assign clr_last  = (clr_reg == AW'(WORDS - 1));
    assign fc_m1     = frame_count - FRAME_W'(1);
    assign last_word = fc_m1[FRAME_W-1:BIT_W];
    assign tail      = frame_count[BIT_W-1:0];

    // frames at or above frame_count read as used
    assign lim_mask  = ((wd_reg == last_word) && (tail != '0))
                       ? ~({WORD_BITS{1'b1}} << tail) : {WORD_BITS{1'b1}};
    assign scan_word = mem_rd_data | ~lim_mask;

    bfa_run_finder u_find (
        .word       (scan_word),
        .run_in     (run_reg),
        .run_length (len_reg),
        .res        (fnd)
    );

    assign hit_end   = {wd_reg, fnd.bit_pos};
    assign hit_start = hit_end + FRAME_W'(1) - len_reg;

    assign mk_lo     = (wd_reg == start_reg[FRAME_W-1:BIT_W]) ? start_reg[BIT_W-1:0] : '0;
    assign mk_hi     = (wd_reg == end_reg[FRAME_W-1:BIT_W]) ? end_reg[BIT_W-1:0] : '1;
    assign mark_mask = ({WORD_BITS{1'b1}} << mk_lo)
                       & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mk_hi));

    assign fbit      = mem_rd_data[idx_reg[BIT_W-1:0]];
    assign fmask     = WORD_BITS'(1) << idx_reg[BIT_W-1:0];

    assign mem_rd_addr = AW'(ptr_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd == CMD_FREE)
                    begin
                        state_next = free_ok ? ST_FREE_RD : ST_RESP;
                    end
                    else
                    begin
                        state_next = alloc_ok ? ST_SCAN : ST_RESP;
                    end
                end
            end
            ST_SCAN:
            begin
                if (live_reg)
                begin
                    if (fnd.hit)
                    begin
                        state_next = ST_MARK;
                    end
                    else if (wd_reg == last_word)
                    begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_MARK:
            begin
                if (live_reg && (wd_reg == end_reg[FRAME_W-1:BIT_W]))
                begin
                    state_next = ST_RESP;
                end
            end
            ST_FREE_RD: state_next = ST_FREE_WR;
            ST_FREE_WR: state_next = ST_RESP;
            ST_RESP:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_clear)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_comb
    begin
        len_next    = len_reg;
        idx_next    = idx_reg;
        used_next   = used_reg;
        run_next    = run_reg;
        start_next  = start_reg;
        end_next    = end_reg;
        ok_next     = ok_reg;
        ptr_next    = ptr_reg;
        wd_next     = wd_reg;
        live_next   = live_reg;
        clr_next    = clr_reg;
        mem_wr_en   = 1'b0;
        mem_wr_addr = AW'(wd_reg);
        mem_wr_data = mem_rd_data | mark_mask;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = clr_reg;
                mem_wr_data = '0;
                clr_next    = clr_reg + AW'(1);
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    len_next   = run_length;
                    idx_next   = frame_index;
                    run_next   = '0;
                    start_next = '0;
                    live_next  = 1'b0;
                    if (cmd == CMD_FREE)
                    begin
                        ok_next  = free_ok;
                        ptr_next = WI_W'(frame_index[IDX_W-1:BIT_W]);
                    end
                    else
                    begin
                        ok_next  = 1'b0;
                        ptr_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                wd_next   = ptr_reg;
                ptr_next  = ptr_reg + WI_W'(1);
                live_next = 1'b1;
                if (live_reg)
                begin
                    if (fnd.hit)
                    begin
                        start_next = hit_start;
                        end_next   = hit_end;
                        used_next  = used_reg + len_reg;
                        ok_next    = 1'b1;
                        ptr_next   = hit_start[FRAME_W-1:BIT_W];
                        live_next  = 1'b0;
                    end
                    else
                    begin
                        run_next = fnd.run_out;
                    end
                end
            end
            ST_MARK:
            begin
                wd_next   = ptr_reg;
                ptr_next  = ptr_reg + WI_W'(1);
                live_next = 1'b1;
                mem_wr_en = live_reg;
            end
            ST_FREE_RD:
            begin
            end
            ST_FREE_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = AW'(ptr_reg);
                mem_wr_data = mem_rd_data & ~fmask;
                if (fbit)
                begin
                    used_next = used_reg - FRAME_W'(1);
                end
            end
            ST_RESP:
            begin
            end
            default:
            begin
            end
        endcase
        if (cfg_clear)
        begin
            clr_next  = '0;
            used_next = '0;
        end
    end

    always_comb
    begin
        in_ready        = (state_reg == ST_IDLE);
        res_valid       = (state_reg == ST_RESP);
        res.success     = ok_reg;
        res.first_frame = start_reg[IDX_W-1:0];
        res.used_count  = used_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            used_reg  <= '0;
            ptr_reg   <= '0;
            live_reg  <= 1'b0;
            clr_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            ptr_reg   <= ptr_next;
            live_reg  <= live_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg   <= len_next;
        idx_reg   <= idx_next;
        run_reg   <= run_next;
        start_reg <= start_next;
        end_reg   <= end_next;
        ok_reg    <= ok_next;
        wd_reg    <= wd_next;
    end

endmodule
